// ----- design/yuv_box_color_classifier_core_assert.svh -----
// Assertion macros shared by the classifier checker.
// Needs clk_i and rst_ni in scope where used.
`ifndef YUV_BOX_COLOR_CLASSIFIER_CORE_ASSERT_SVH
`define YUV_BOX_COLOR_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define YBCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define YBCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ybcc_pkg.sv -----
// Types, constants and helpers for the YUV box color classifier.
// No dependencies; used by every module of the block.
`default_nettype none

package ybcc_pkg;

  localparam int unsigned LABEL_W   = 4;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned SUM_W     = 18;
  localparam int unsigned THR_W     = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned S_TDATA_W = 80;
  localparam int unsigned M_TDATA_W = 8;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [LABEL_W-1:0] NO_COLOR   = 4'd11;
  localparam logic [CH_W-1:0]    QUANT_MASK = 8'h0F;

  // Fixed-point coefficients (scaled by 1024) and chroma bias of 128 * 1024
  localparam logic [SUM_W-1:0] KY_R  = 18'd306;
  localparam logic [SUM_W-1:0] KY_G  = 18'd601;
  localparam logic [SUM_W-1:0] KY_B  = 18'd117;
  localparam logic [SUM_W-1:0] KU_R  = 18'd172;
  localparam logic [SUM_W-1:0] KU_G  = 18'd340;
  localparam logic [SUM_W-1:0] KUV_P = 18'd512;
  localparam logic [SUM_W-1:0] KV_G  = 18'd419;
  localparam logic [SUM_W-1:0] KV_B  = 18'd83;
  localparam logic [SUM_W-1:0] CHROMA_BIAS = 18'd131072;

  // Input tdata bit positions, lowest field first
  localparam int unsigned POS_IDX   = 0;
  localparam int unsigned POS_YMIN  = 4;
  localparam int unsigned POS_YMAX  = 12;
  localparam int unsigned POS_UMIN  = 20;
  localparam int unsigned POS_UMAX  = 28;
  localparam int unsigned POS_VMIN  = 36;
  localparam int unsigned POS_VMAX  = 44;
  localparam int unsigned POS_RED   = 52;
  localparam int unsigned POS_GREEN = 60;
  localparam int unsigned POS_BLUE  = 68;

  typedef enum logic [0:0] {
    CMD_CLASSIFY = 1'b0,
    CMD_WRITE    = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAY_THRESHOLD = 1'b0,
    REG_QUANTIZE       = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0] v_max;
    logic [CH_W-1:0] v_min;
    logic [CH_W-1:0] u_max;
    logic [CH_W-1:0] u_min;
    logic [CH_W-1:0] y_max;
    logic [CH_W-1:0] y_min;
  } bounds_t;

  // One queued operation: a bounds write or a converted pixel
  typedef struct packed {
    cmd_e             cmd;
    logic [IDX_W-1:0] class_index;
    bounds_t          bounds;
    logic             gray;
    logic [CH_W-1:0]  y;
    logic [CH_W-1:0]  u;
    logic [CH_W-1:0]  v;
  } entry_t;

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ----- design/yuv_box_color_classifier_core.sv -----
// Top level of the YUV box color classifier: front end, queue, back end.
// Depends on ybcc_pkg, ybcc_front, ybcc_fifo and ybcc_back.
//
// Channel   Dir  Beat contents (lowest bits first)
// s_axis    in   tuser: command; tdata: class_index, y_min, y_max, u_min,
//                u_max, v_min, v_max, red, green, blue, zero pad to 80 bits
// m_axis    out  tdata: label, zero pad to 8 bits (one beat per pixel)
// cfg       in   cfg_we_i, cfg_idx_i (0 gray threshold, 1 quantize), cfg_data_i
//
// One beat per clock sustained while m_axis_tready is high; a pixel's label
// passes through the input stage register, the queue and the output register.
// Bound writes take effect in order with pixels and produce no output beat.
// Reset clears config, all class bounds and every valid flag.
// The four-entry queue absorbs output stalls; input stalls only when it fills.
`default_nettype none

module yuv_box_color_classifier_core #(
  parameter int unsigned NUM_CLASSES = 11
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [ybcc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ybcc_pkg::CFG_W-1:0]        cfg_data_i,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // [3:0] class_index, [11:4] y_min, [19:12] y_max, [27:20] u_min,
  // [35:28] u_max, [43:36] v_min, [51:44] v_max, [59:52] red,
  // [67:60] green, [75:68] blue, [79:76] zero
  input  wire logic [ybcc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // [0] command
  input  wire logic                              s_axis_tuser,
  // output stream
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [3:0] label, [7:4] zero
  output      logic [ybcc_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  logic                          push, pop, full, empty;
  ybcc_pkg::entry_t              push_entry, pop_entry;
  logic [ybcc_pkg::LABEL_W-1:0]  label;

  // Front: accept beats, hold config, classify gray and form YUV sums
  ybcc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .push_o       (push),
    .push_entry_o (push_entry),
    .full_i       (full)
  );

  // Queue: decouple the front from output back-pressure
  ybcc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .empty_o      (empty)
  );

  // Back: apply bound writes, match boxes, hold the label until taken
  ybcc_back #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_label_o (label)
  );

  // Pad the label to a whole byte
  assign m_axis_tdata = {{(ybcc_pkg::M_TDATA_W - ybcc_pkg::LABEL_W){1'b0}}, label};

endmodule

`default_nettype wire

// ----- design/ybcc_front.sv -----
// Front end: config registers, input accept, quantize, gray test and YUV sums.
// Depends on ybcc_pkg; feeds ybcc_fifo.
`default_nettype none

module ybcc_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ybcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ybcc_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic                            in_cmd_i,
  input  wire logic [ybcc_pkg::S_TDATA_W-1:0]  in_data_i,
  output      logic                            push_o,
  output      ybcc_pkg::entry_t                push_entry_o,
  input  wire logic                            full_i
);

  logic [ybcc_pkg::THR_W-1:0] thr_q;
  logic                       quant_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      quant_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (ybcc_pkg::reg_idx_e'(cfg_idx_i))
        ybcc_pkg::REG_GRAY_THRESHOLD: thr_q   <= cfg_data_i;
        ybcc_pkg::REG_QUANTIZE:       quant_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [ybcc_pkg::CH_W-1:0] r, g, b;
  logic [ybcc_pkg::CH_W-1:0] d_rg, d_rb, d_bg;
  logic                      gray_d;
  logic [ybcc_pkg::SUM_W-1:0] sy_d, su_d, sv_d;
  ybcc_pkg::bounds_t          bnd_d;

  always_comb begin
    r = in_data_i[ybcc_pkg::POS_RED   +: ybcc_pkg::CH_W];
    g = in_data_i[ybcc_pkg::POS_GREEN +: ybcc_pkg::CH_W];
    b = in_data_i[ybcc_pkg::POS_BLUE  +: ybcc_pkg::CH_W];
    if (quant_q) begin
      r = r | ybcc_pkg::QUANT_MASK;
      g = g | ybcc_pkg::QUANT_MASK;
      b = b | ybcc_pkg::QUANT_MASK;
    end
    d_rg   = ybcc_pkg::abs_diff(r, g);
    d_rb   = ybcc_pkg::abs_diff(r, b);
    d_bg   = ybcc_pkg::abs_diff(b, g);
    gray_d = ({1'b0, d_rg} < thr_q) && ({1'b0, d_rb} < thr_q) && ({1'b0, d_bg} < thr_q);
    // All three sums land in 0..2^18-1 for 8-bit channels, so the 18-bit
    // wrap is exact and no clamp to 0..255 is needed.
    sy_d = ybcc_pkg::KY_R * ybcc_pkg::SUM_W'(r) + ybcc_pkg::KY_G * ybcc_pkg::SUM_W'(g)
         + ybcc_pkg::KY_B * ybcc_pkg::SUM_W'(b);
    su_d = ybcc_pkg::CHROMA_BIAS + ybcc_pkg::KUV_P * ybcc_pkg::SUM_W'(b)
         - ybcc_pkg::KU_R * ybcc_pkg::SUM_W'(r) - ybcc_pkg::KU_G * ybcc_pkg::SUM_W'(g);
    sv_d = ybcc_pkg::CHROMA_BIAS + ybcc_pkg::KUV_P * ybcc_pkg::SUM_W'(r)
         - ybcc_pkg::KV_G * ybcc_pkg::SUM_W'(g) - ybcc_pkg::KV_B * ybcc_pkg::SUM_W'(b);
    bnd_d.y_min = in_data_i[ybcc_pkg::POS_YMIN +: ybcc_pkg::CH_W];
    bnd_d.y_max = in_data_i[ybcc_pkg::POS_YMAX +: ybcc_pkg::CH_W];
    bnd_d.u_min = in_data_i[ybcc_pkg::POS_UMIN +: ybcc_pkg::CH_W];
    bnd_d.u_max = in_data_i[ybcc_pkg::POS_UMAX +: ybcc_pkg::CH_W];
    bnd_d.v_min = in_data_i[ybcc_pkg::POS_VMIN +: ybcc_pkg::CH_W];
    bnd_d.v_max = in_data_i[ybcc_pkg::POS_VMAX +: ybcc_pkg::CH_W];
  end

  // Single stage register between the input and the queue
  logic                        vld_q;
  ybcc_pkg::cmd_e              cmd_q;
  logic [ybcc_pkg::IDX_W-1:0]  idx_q;
  ybcc_pkg::bounds_t           bnd_q;
  logic                        gray_q;
  logic [ybcc_pkg::SUM_W-1:0]  sy_q, su_q, sv_q;
  logic                        load;

  assign push_o     = vld_q && !full_i;
  assign in_ready_o = !vld_q || !full_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q  <= ybcc_pkg::cmd_e'(in_cmd_i);
      idx_q  <= in_data_i[ybcc_pkg::POS_IDX +: ybcc_pkg::IDX_W];
      bnd_q  <= bnd_d;
      gray_q <= gray_d;
      sy_q   <= sy_d;
      su_q   <= su_d;
      sv_q   <= sv_d;
    end
  end

  always_comb begin
    push_entry_o.cmd         = cmd_q;
    push_entry_o.class_index = idx_q;
    push_entry_o.bounds      = bnd_q;
    push_entry_o.gray        = gray_q;
    push_entry_o.y           = sy_q[ybcc_pkg::SUM_W-1 -: ybcc_pkg::CH_W];
    push_entry_o.u           = su_q[ybcc_pkg::SUM_W-1 -: ybcc_pkg::CH_W];
    push_entry_o.v           = sv_q[ybcc_pkg::SUM_W-1 -: ybcc_pkg::CH_W];
  end

endmodule

`default_nettype wire

// ----- design/ybcc_fifo.sv -----
// Short queue of operations between front end and back end.
// Depends on ybcc_pkg.
`default_nettype none

module ybcc_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ybcc_pkg::entry_t push_entry_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      ybcc_pkg::entry_t pop_entry_o,
  output      logic             empty_o
);

  ybcc_pkg::entry_t                 mem_q [ybcc_pkg::FIFO_DEPTH];
  logic [ybcc_pkg::FIFO_PTR_W-1:0]  wptr_q, rptr_q;
  logic [ybcc_pkg::FIFO_PTR_W:0]    cnt_q;

  assign full_o      = (cnt_q == (ybcc_pkg::FIFO_PTR_W+1)'(ybcc_pkg::FIFO_DEPTH));
  assign empty_o     = (cnt_q == '0);
  assign pop_entry_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_entry_i;
  end

endmodule

`default_nettype wire

// ----- design/ybcc_back.sv -----
// Back end: class bound registers, box match and the output register.
// Depends on ybcc_pkg; drains ybcc_fifo.
`default_nettype none

module ybcc_back #(
  parameter int unsigned NUM_CLASSES = 11
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           empty_i,
  input  wire ybcc_pkg::entry_t               entry_i,
  output      logic                           pop_o,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      logic [ybcc_pkg::LABEL_W-1:0]   out_label_o
);

  localparam int unsigned CI_W = 6;

  ybcc_pkg::bounds_t             bnd_q [NUM_CLASSES];
  logic                          vld_q;
  logic [ybcc_pkg::LABEL_W-1:0]  label_q;
  logic [ybcc_pkg::LABEL_W-1:0]  label_d;
  logic                          is_wr, is_px, out_free;

  assign is_wr    = !empty_i && (entry_i.cmd == ybcc_pkg::CMD_WRITE);
  assign is_px    = !empty_i && (entry_i.cmd == ybcc_pkg::CMD_CLASSIFY);
  assign out_free = !vld_q || out_ready_i;
  assign pop_o    = is_wr || (is_px && out_free);

  // Lowest matching class wins; walk from the top so lower ones override; gray forces NO_COLOR
  always_comb begin
    label_d = ybcc_pkg::NO_COLOR;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (entry_i.y >= bnd_q[k].y_min && entry_i.y <= bnd_q[k].y_max &&
          entry_i.u >= bnd_q[k].u_min && entry_i.u <= bnd_q[k].u_max &&
          entry_i.v >= bnd_q[k].v_min && entry_i.v <= bnd_q[k].v_max) begin
        label_d = ybcc_pkg::LABEL_W'(k);
      end
    end
    if (entry_i.gray) label_d = ybcc_pkg::NO_COLOR;
  end

  // Out-of-range class indexes match no entry and drop silently
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CLASSES; k++) bnd_q[k] <= '0;
    end else if (is_wr) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        if ({2'b00, entry_i.class_index} == CI_W'(k)) bnd_q[k] <= entry_i.bounds;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (is_px && out_free) begin
      vld_q <= 1'b1;
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_px && out_free) label_q <= label_d;
  end

  assign out_valid_o = vld_q;
  assign out_label_o = label_q;

endmodule

`default_nettype wire

// ----- design/ybcc_checker.sv -----
// Port-level checker for the classifier top level, with its bind.
// Depends on ybcc_pkg and yuv_box_color_classifier_core_assert.svh.
`default_nettype none

`include "yuv_box_color_classifier_core_assert.svh"

module ybcc_checker #(
  parameter int unsigned NUM_CLASSES = 11
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [ybcc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  `YBCC_ASSERT_NEXT(a_out_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output beat dropped while stalled")
  `YBCC_ASSERT_NEXT(a_out_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output data changed while stalled")
  `YBCC_ASSERT_SAME(a_pad_zero, m_axis_tvalid, m_axis_tdata[7:4] == 4'd0, "label padding not zero")
  `YBCC_ASSERT_SAME(a_label_range, m_axis_tvalid, (32'(m_axis_tdata[3:0]) < NUM_CLASSES) || (m_axis_tdata[3:0] == ybcc_pkg::NO_COLOR), "label out of class range")

endmodule

bind yuv_box_color_classifier_core ybcc_checker #(
  .NUM_CLASSES (NUM_CLASSES)
) u_ybcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
